/* rtl/mdio_mm_pkg.sv */
// ----------------------------------------------------------------------------
// MDIO management master package
// Frame constants and the per-period line status shared by the master files.
// ----------------------------------------------------------------------------
package mdio_mm_pkg;

  localparam int unsigned HeaderBits    = 32;
  localparam int unsigned PosWidth      = 6;
  localparam int unsigned DataWidth     = 16;
  localparam int unsigned AddrWidth     = 5;

  localparam logic [PosWidth-1:0] MaxPreamble   = 6'd32;
  localparam logic [PosWidth-1:0] PreambleReset = 6'd32;
  localparam logic [PosWidth-1:0] PreambleBase  = 6'd31;

  // clause 22 field codes
  localparam logic [1:0] StartCode  = 2'b01;
  localparam logic [1:0] OpRead     = 2'b10;
  localparam logic [1:0] OpWrite    = 2'b01;
  localparam logic [1:0] TaWrite    = 2'b10;
  localparam logic [1:0] TaRead     = 2'b00;

  // header bit index from which a read frame releases the line / samples data
  localparam logic [4:0] ReleaseIdx = 5'd14;
  localparam logic [4:0] SampleIdx  = 5'd16;
  localparam logic [4:0] LastIdx    = 5'd31;

  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;

  typedef struct packed {
    logic mdio_out;
    logic mdio_drive;
    logic busy;
    logic done;
  } line_t;

endpackage

/* rtl/mdio_mm_core.sv */
// ----------------------------------------------------------------------------
// MDIO management master frame core
// Frame state and the per-period bit logic: one MDC period per step.
// ----------------------------------------------------------------------------
module mdio_mm_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    step_i,
  input  logic [mdio_mm_pkg::PosWidth-1:0]        preamble_length_i,
  input  logic                                    start_req_i,
  input  logic                                    mode_i,
  input  logic [mdio_mm_pkg::AddrWidth-1:0]       phy_addr_i,
  input  logic [mdio_mm_pkg::AddrWidth-1:0]       reg_addr_i,
  input  logic [mdio_mm_pkg::DataWidth-1:0]       write_data_i,
  input  logic                                    mdio_in_i,
  output mdio_mm_pkg::line_t                      line_o,
  output logic [mdio_mm_pkg::DataWidth-1:0]       read_data_o
);

  logic [mdio_mm_pkg::PosWidth-1:0]   pos_q, pos_d, pos_s;
  logic                               active_q, active_d, active_s;
  logic                               is_read_q, is_read_s;
  logic [mdio_mm_pkg::HeaderBits-1:0] hdr_q, hdr_s, hdr_new;
  logic [mdio_mm_pkg::DataWidth-1:0]  cap_q, cap_d, cap_s;
  logic [mdio_mm_pkg::PosWidth-1:0]   pre;
  logic                               start;
  logic [4:0]                         idx;
  mdio_mm_pkg::line_t                 line;

  assign start = !active_q && start_req_i;
  assign pre   = (preamble_length_i > mdio_mm_pkg::MaxPreamble) ?
                 mdio_mm_pkg::MaxPreamble : preamble_length_i;

  assign hdr_new = {mdio_mm_pkg::StartCode,
                    (mode_i == mdio_mm_pkg::ModeWrite) ? mdio_mm_pkg::OpWrite
                                                       : mdio_mm_pkg::OpRead,
                    phy_addr_i, reg_addr_i,
                    (mode_i == mdio_mm_pkg::ModeWrite) ? mdio_mm_pkg::TaWrite
                                                       : mdio_mm_pkg::TaRead,
                    (mode_i == mdio_mm_pkg::ModeWrite) ? write_data_i
                                                       : {mdio_mm_pkg::DataWidth{1'b0}}};

  always_comb begin
    pos_s     = pos_q;
    hdr_s     = hdr_q;
    is_read_s = is_read_q;
    cap_s     = cap_q;
    if (start) begin
      hdr_s     = hdr_new;
      is_read_s = (mode_i == mdio_mm_pkg::ModeRead);
      pos_s     = (pre != '0) ? mdio_mm_pkg::PreambleBase + pre : '0;
      if (mode_i == mdio_mm_pkg::ModeRead) begin
        cap_s = '0;
      end
    end
    active_s = active_q || start;

    idx      = pos_s[4:0];
    line     = '0;
    pos_d    = pos_s;
    active_d = active_s;
    cap_d    = cap_s;
    if (active_s) begin
      line.busy = 1'b1;
      if (pos_s[mdio_mm_pkg::PosWidth-1]) begin
        line.mdio_out   = 1'b1;
        line.mdio_drive = 1'b1;
        pos_d = (pos_s == mdio_mm_pkg::MaxPreamble) ? '0 : pos_s - 1'b1;
      end else begin
        if (!(is_read_s && idx >= mdio_mm_pkg::ReleaseIdx)) begin
          line.mdio_out   = hdr_s[mdio_mm_pkg::LastIdx - idx];
          line.mdio_drive = 1'b1;
        end
        if (is_read_s && idx >= mdio_mm_pkg::SampleIdx) begin
          cap_d = {cap_s[mdio_mm_pkg::DataWidth-2:0], mdio_in_i};
        end
        if (idx == mdio_mm_pkg::LastIdx) begin
          line.done = 1'b1;
          active_d  = 1'b0;
          pos_d     = '0;
        end else begin
          pos_d = {1'b0, idx + 5'd1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      active_q  <= 1'b0;
      is_read_q <= 1'b0;
      hdr_q     <= '0;
      cap_q     <= '0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      active_q  <= active_d;
      is_read_q <= is_read_s;
      hdr_q     <= hdr_s;
      cap_q     <= cap_d;
    end
  end

  assign line_o      = line;
  assign read_data_o = cap_d;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line.done |-> line.busy) else $error("done outside a frame");

  a_released_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !line.mdio_drive |-> !line.mdio_out) else $error("released line not low");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && line.done) |=> !active_q) else $error("frame active after done");

  a_preamble_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && pos_q[mdio_mm_pkg::PosWidth-1]) |-> (line.mdio_out && line.mdio_drive))
    else $error("preamble bit not a driven one");

endmodule

/* rtl/mdio_management_master.sv */
// ----------------------------------------------------------------------------
// MDIO management master (clause 22)
// Frame generator driven one MDC period per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one MDC period: a start request (taken only while no
// frame runs) with mode, addresses and write data, plus the sampled line level.
// Each input transfer gives exactly one output transfer with the driven level,
// the drive enable, busy, done (last period of a frame) and the read register.
// A frame lasts preamble_length + 32 periods, with preamble_length above 32
// counted as 32; it is written on cfg_we_i / cfg_wdata_i and is sampled when
// a frame starts.
// The output transfer is registered. One transfer is taken every cycle unless
// in_stall_o is raised; the frame state and the per-period bit logic sit
// between the input and the output register.
// When the receiver stalls, the output register holds its transfer and
// in_stall_o is raised, so no new period is taken until it drains.
// Reset clears the frame state and the read register, empties the output
// register and sets preamble_length to 32.
// ----------------------------------------------------------------------------
module mdio_management_master (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [mdio_mm_pkg::PosWidth-1:0]        cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    start_req_i,
  input  logic                                    mode_i,
  input  logic [mdio_mm_pkg::AddrWidth-1:0]       phy_addr_i,
  input  logic [mdio_mm_pkg::AddrWidth-1:0]       reg_addr_i,
  input  logic [mdio_mm_pkg::DataWidth-1:0]       write_data_i,
  input  logic                                    mdio_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    mdio_out_o,
  output logic                                    mdio_drive_o,
  output logic                                    busy_res_o,
  output logic                                    done_res_o,
  output logic [mdio_mm_pkg::DataWidth-1:0]       read_data_o
);

  logic [mdio_mm_pkg::PosWidth-1:0]  pre_len_q;
  logic                              out_valid_q, out_valid_d;
  mdio_mm_pkg::line_t                line, line_q;
  logic [mdio_mm_pkg::DataWidth-1:0] rdata, rdata_q;
  logic                              accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_len_q <= mdio_mm_pkg::PreambleReset;
    end else if (cfg_we_i) begin
      pre_len_q <= cfg_wdata_i;
    end
  end

  mdio_mm_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (accept),
    .preamble_length_i (pre_len_q),
    .start_req_i       (start_req_i),
    .mode_i            (mode_i),
    .phy_addr_i        (phy_addr_i),
    .reg_addr_i        (reg_addr_i),
    .write_data_i      (write_data_i),
    .mdio_in_i         (mdio_in_i),
    .line_o            (line),
    .read_data_o       (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q  <= line;
      rdata_q <= rdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mdio_out_o   = line_q.mdio_out;
  assign mdio_drive_o = line_q.mdio_drive;
  assign busy_res_o   = line_q.busy;
  assign done_res_o   = line_q.done;
  assign read_data_o  = rdata_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !accept) else $error("held transfer overwritten");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q) else $error("accepted period gave no transfer");

  a_cfg_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_we_i) |-> $stable(pre_len_q)) else $error("preamble length changed");

endmodule

/* tb/mdio_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MDIO management master checker
// Watches both transfer channels and the preamble register port. It keeps its
// own copy of the frame state to work out each period's line status and read
// register, then compares every output transfer with the oldest expected one.
// ----------------------------------------------------------------------------
module mdio_frame_checker
  import mdio_mm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [PosWidth-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 start_req_i,
  input  logic                 mode_i,
  input  logic [AddrWidth-1:0] phy_addr_i,
  input  logic [AddrWidth-1:0] reg_addr_i,
  input  logic [DataWidth-1:0] write_data_i,
  input  logic                 mdio_in_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 mdio_out_i,
  input  logic                 mdio_drive_i,
  input  logic                 busy_res_i,
  input  logic                 done_res_i,
  input  logic [DataWidth-1:0] read_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   read_frames_o,
  output int                   write_frames_o
);

  localparam int ReportLimit = 10;

  typedef struct packed {
    line_t                line;
    logic [DataWidth-1:0] read_data;
  } period_t;

  period_t              period_q[$];
  logic [PosWidth-1:0]  preamble_len;
  logic [PosWidth-1:0]  bit_pos;
  logic                 frame_on;
  logic                 frame_rd;
  logic [HeaderBits-1:0] header;
  logic [DataWidth-1:0] capture;
  int                   mismatches;
  int                   rd_frames;
  int                   wr_frames;

  function automatic period_t mdc_period(input logic start, input logic md,
                                         input logic [AddrWidth-1:0] pa,
                                         input logic [AddrWidth-1:0] ra,
                                         input logic [DataWidth-1:0] wd,
                                         input logic smp);
    period_t p;
    logic [PosWidth-1:0] pre;
    logic [4:0] idx;
    p = '0;
    if (!frame_on && start) begin
      pre = (preamble_len > MaxPreamble) ? MaxPreamble : preamble_len;
      frame_rd = (md == ModeRead);
      header = {StartCode, frame_rd ? OpRead : OpWrite, pa, ra,
                frame_rd ? TaRead : TaWrite, frame_rd ? {DataWidth{1'b0}} : wd};
      bit_pos = (pre != 0) ? PreambleBase + pre : '0;
      frame_on = 1'b1;
      if (frame_rd) begin
        capture = '0;
        rd_frames++;
      end else begin
        wr_frames++;
      end
    end
    if (frame_on) begin
      p.line.busy = 1'b1;
      if (bit_pos >= HeaderBits) begin
        p.line.mdio_out = 1'b1;
        p.line.mdio_drive = 1'b1;
        bit_pos = (bit_pos == HeaderBits) ? '0 : bit_pos - 1'b1;
      end else begin
        idx = bit_pos[4:0];
        if (!(frame_rd && idx >= ReleaseIdx)) begin
          p.line.mdio_out = header[LastIdx - idx];
          p.line.mdio_drive = 1'b1;
        end
        if (frame_rd && idx >= SampleIdx) capture = {capture[DataWidth-2:0], smp};
        if (idx == LastIdx) begin
          p.line.done = 1'b1;
          frame_on = 1'b0;
          bit_pos = '0;
        end else begin
          bit_pos = idx + 1'b1;
        end
      end
    end
    p.read_data = capture;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    period_t want;
    period_t got;
    if (!rst_ni) begin
      period_q.delete();
      preamble_len = PreambleReset;
      bit_pos = '0;
      frame_on = 1'b0;
      frame_rd = 1'b0;
      header = '0;
      capture = '0;
      mismatches = 0;
      rd_frames = 0;
      wr_frames = 0;
      errors_o <= 0;
      pending_o <= 0;
      read_frames_o <= 0;
      write_frames_o <= 0;
    end else begin
      if (cfg_we_i) preamble_len = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        period_q.push_back(mdc_period(start_req_i, mode_i, phy_addr_i, reg_addr_i,
                                      write_data_i, mdio_in_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = {mdio_out_i, mdio_drive_i, busy_res_i, done_res_i, read_data_i};
        if (period_q.size() == 0) begin
          if (mismatches < ReportLimit)
            $display("%0t: output transfer with nothing expected: %p", $realtime, got);
          mismatches++;
        end else begin
          want = period_q.pop_front();
          if (got !== want) begin
            if (mismatches < ReportLimit)
              $display("%0t: mismatch out/drv/busy/done/rdata exp %b %b %b %b %h got %b %b %b %b %h",
                       $realtime,
                       want.line.mdio_out, want.line.mdio_drive, want.line.busy,
                       want.line.done, want.read_data, mdio_out_i, mdio_drive_i,
                       busy_res_i, done_res_i, read_data_i);
            mismatches++;
          end
        end
      end
      errors_o <= mismatches;
      pending_o <= period_q.size();
      read_frames_o <= rd_frames;
      write_frames_o <= wr_frames;
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MDIO management master testbench
// Drives MDC periods into the master: directed read and write frames at the
// preamble extremes, a start while busy and a preamble change mid-frame, then
// random frames over several preamble settings, idling randomly on both sides
// but in the last. The checker beside the block predicts and compares every period.
// ----------------------------------------------------------------------------
module tb;
  import mdio_mm_pkg::*;

  localparam int QuietLimit    = 500;
  localparam int PhasePeriods  = 110;
  localparam int DrainCycles   = 8;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [PosWidth-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 start_req_i = 1'b0;
  logic                 mode_i = ModeRead;
  logic [AddrWidth-1:0] phy_addr_i = '0;
  logic [AddrWidth-1:0] reg_addr_i = '0;
  logic [DataWidth-1:0] write_data_i = '0;
  logic                 mdio_in_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 mdio_out_o;
  logic                 mdio_drive_o;
  logic                 busy_res_o;
  logic                 done_res_o;
  logic [DataWidth-1:0] read_data_o;

  int errors;
  int pending;
  int read_frames;
  int write_frames;

  bit                  idle_on = 1'b1;
  int                  stall_left = 0;
  int                  quiet_cycles = 0;
  int                  periods = 0;
  logic [PosWidth-1:0] cur_pre = PreambleReset;
  logic [PosWidth-1:0] phase_pre [8] = '{6'd0, 6'd32, 6'd1, 6'd63, 6'd33, 6'd17, 6'd0, 6'd5};

  always #2 clk_i = ~clk_i;

  mdio_management_master dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_req_i  (start_req_i),
    .mode_i       (mode_i),
    .phy_addr_i   (phy_addr_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .mdio_in_i    (mdio_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mdio_out_o   (mdio_out_o),
    .mdio_drive_o (mdio_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_data_o  (read_data_o)
  );

  mdio_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .start_req_i    (start_req_i),
    .mode_i         (mode_i),
    .phy_addr_i     (phy_addr_i),
    .reg_addr_i     (reg_addr_i),
    .write_data_i   (write_data_i),
    .mdio_in_i      (mdio_in_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mdio_out_i     (mdio_out_o),
    .mdio_drive_i   (mdio_drive_o),
    .busy_res_i     (busy_res_o),
    .done_res_i     (done_res_o),
    .read_data_i    (read_data_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .read_frames_o  (read_frames),
    .write_frames_o (write_frames)
  );

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (rst_ni && idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("tb: no transfer for %0d cycles", QuietLimit);
        $display("tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_period(input logic start, input logic md,
                             input logic [AddrWidth-1:0] pa,
                             input logic [AddrWidth-1:0] ra,
                             input logic [DataWidth-1:0] wd);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_req_i <= start;
    mode_i <= md;
    phy_addr_i <= pa;
    reg_addr_i <= ra;
    write_data_i <= wd;
    mdio_in_i <= 1'($urandom_range(0, 1));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    periods++;
  endtask

  task automatic quiet_periods(input int n);
    repeat (n) send_period(1'b0, 1'($urandom_range(0, 1)), 5'($urandom), 5'($urandom),
                           16'($urandom));
  endtask

  task automatic mdio_frame(input logic md, input logic [AddrWidth-1:0] pa,
                            input logic [AddrWidth-1:0] ra,
                            input logic [DataWidth-1:0] wd);
    send_period(1'b1, md, pa, ra, wd);
    quiet_periods(((cur_pre > MaxPreamble) ? MaxPreamble : cur_pre) + HeaderBits - 1);
  endtask

  // hold off until every expected period is back, then write the register
  task automatic set_preamble(input logic [PosWidth-1:0] len);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_pre = len;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset preamble, start while busy is ignored
    send_period(1'b1, ModeRead, 5'd31, 5'd0, 16'h0000);
    quiet_periods(4);
    send_period(1'b1, ModeWrite, 5'd0, 5'd31, 16'hFFFF);
    quiet_periods(58);
    quiet_periods(2);
    mdio_frame(ModeWrite, 5'd0, 5'd31, 16'hFFFF);

    // preamble suppression, back-to-back frames
    set_preamble(6'd0);
    mdio_frame(ModeWrite, 5'd31, 5'd31, 16'h0000);
    mdio_frame(ModeRead, 5'd0, 5'd31, 16'hFFFF);
    mdio_frame(ModeWrite, 5'd21, 5'd10, 16'hA5C3);
    set_preamble(6'd1);
    mdio_frame(ModeRead, 5'd10, 5'd21, 16'h0000);
    set_preamble(6'd63);
    mdio_frame(ModeRead, 5'd31, 5'd31, 16'h5A5A);

    // register change while a frame runs
    set_preamble(6'd2);
    send_period(1'b1, ModeWrite, 5'd3, 5'd12, 16'h8001);
    quiet_periods(3);
    set_preamble(6'd40);
    quiet_periods(30);
    mdio_frame(ModeRead, 5'd7, 5'd1, 16'h0000);

    phase_pre[5] = 6'($urandom_range(0, 63));
    phase_pre[7] = 6'($urandom_range(0, 63));
    foreach (phase_pre[p]) begin
      if (p == 7) idle_on = 1'b0;
      set_preamble(phase_pre[p]);
      repeat (PhasePeriods) begin
        send_period(1'($urandom_range(0, 2) == 0), 1'($urandom_range(0, 1)),
                    5'($urandom), 5'($urandom), 16'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d MDC periods, %0d read and %0d write frames started", periods,
             read_frames, write_frames);
    $display("tb: preamble lengths 0, 1, 32, above 32 and random, one change mid-frame");
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
